### rtl/lpht_pkg.sv
// Package: shared constants, operation and status codes, and controller/datapath structs.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int KEY_W   = 31;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 5;
  localparam int DIV_CW  = 1;

  localparam int TABLE_SLOTS_DEF  = 32;
  localparam int HOME_MODULUS_DEF = 10;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;       // capture func and key, start residue
    logic              div_step;   // one step of key mod HOME_MODULUS
    logic              scan_init;  // pointer to home slot
    logic              ptr_inc;    // advance pointer
    logic              wr;         // write slot at pointer
    logic              wr_zero;    // write data forced to empty
    logic              res_en;     // present a result next cycle
    logic [STAT_W-1:0] res_st;     // result status
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_invalid;  // zero key or unused operation at the inputs
    logic div_done;    // current residue step is the last one
    logic home_out;    // home slot at or past the end of the table
    logic hit;         // slot read holds the value looked for
    logic last;        // pointer at the last slot
    logic is_insert;
    logic is_search;
  } sts_t;

endpackage

`default_nettype wire

### rtl/lpht_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/lpht_ctrl.sv
// Controller: sequences clear pass, residue, home check and slot scan.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o,
  output      logic busy_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_HOME = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wr_zero = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        if (sts_i.last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_invalid) begin
            cmd_o.res_en = 1'b1;
            cmd_o.res_st = ST_INVALID;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_HOME;
        end
      end
      S_HOME: begin
        if (sts_i.home_out) begin
          cmd_o.res_en = 1'b1;
          cmd_o.res_st = sts_i.is_insert ? ST_FULL : ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_RD;
        end
      end
      S_RD: begin
        // wait for registered read data
        state_d = S_CMP;
      end
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.wr     = !sts_i.is_search;
          cmd_o.res_en = 1'b1;
          cmd_o.res_st = ST_OK;
          state_d      = S_IDLE;
        end else if (sts_i.last) begin
          cmd_o.res_en = 1'b1;
          cmd_o.res_st = sts_i.is_insert ? ST_FULL : ST_NOT_FOUND;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/lpht_dp.sv
// Datapath: operand registers, reciprocal residue, slot pointer, table RAM, result registers.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
  parameter int HOME_MODULUS = HOME_MODULUS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire cmd_t              cmd_i,
  output      sts_t              sts_o,
  output      logic              done_o,
  output      logic [STAT_W-1:0] status_o,
  output      logic [SLOT_W-1:0] slot_o
);

  localparam int AW  = $clog2(TABLE_SLOTS);
  localparam int RW  = $clog2(HOME_MODULUS);
  localparam int HW  = $clog2(HOME_MODULUS + 1);
  localparam int CW  = (HW > AW + 1) ? HW : AW + 1;
  localparam int PW  = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int PRW = 2 * KEY_W + 1;

  // ceil(2^(KEY_W+RW) / HOME_MODULUS): exact quotient for every KEY_W-bit key
  localparam logic [63:0] MAGIC_WIDE =
    ((64'd1 << (KEY_W + RW)) + 64'(HOME_MODULUS - 1)) / 64'(HOME_MODULUS);
  localparam logic [KEY_W:0] MAGIC = MAGIC_WIDE[KEY_W:0];

  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  quot_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [RW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     ptr_q;
  logic              done_q;
  logic [STAT_W-1:0] status_q;
  logic [SLOT_W-1:0] slot_q;

  logic [PRW-1:0]    prod;
  logic [KEY_W-1:0]  quot;
  logic [HW-1:0]     home;
  logic [CW-1:0]     home_ext;
  logic [PW-1:0]     ptr_ext;
  logic [KEY_W-1:0]  rdata;
  logic [KEY_W-1:0]  wdata;
  logic [KEY_W-1:0]  target;

  // Quotient by reciprocal multiply in the first step, remainder in the second
  assign prod  = PRW'(key_q) * PRW'(MAGIC);
  assign quot  = KEY_W'(prod >> (KEY_W + RW));
  assign rem_d = RW'(key_q - quot_q * KEY_W'(HOME_MODULUS));

  // A zero residue maps to the modulus itself
  assign home     = (rem_q == '0) ? HW'(HOME_MODULUS) : HW'(rem_q);
  assign home_ext = CW'(home);
  assign ptr_ext  = PW'(ptr_q);

  assign target = (func_q == FN_INSERT) ? '0 : key_q;
  assign wdata  = (cmd_i.wr_zero || func_q != FN_INSERT) ? '0 : key_q;

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (ptr_q),
    .wdata_i (wdata),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= key_i;
    end else if (cmd_i.div_step) begin
      quot_q <= quot;
    end
    if (cmd_i.res_en) begin
      status_q <= cmd_i.res_st;
      slot_q   <= (cmd_i.res_st == ST_OK) ? ptr_ext[SLOT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rem_q  <= '0;
      ptr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_en;
      if (cmd_i.load) begin
        cnt_q <= DIV_CW'(1);
        rem_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_q <= rem_d;
        end
      end
      if (cmd_i.scan_init) begin
        ptr_q <= home_ext[AW-1:0];
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= (ptr_q == AW'(TABLE_SLOTS - 1)) ? '0 : ptr_q + AW'(1);
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.in_invalid = (key_i == '0) || (func_i == FN_UNUSED);
    sts_o.div_done   = (cnt_q == '0);
    sts_o.home_out   = (home_ext >= CW'(TABLE_SLOTS));
    sts_o.hit        = (rdata == target);
    sts_o.last       = (ptr_q == AW'(TABLE_SLOTS - 1));
    sts_o.is_insert  = (func_q == FN_INSERT);
    sts_o.is_search  = (func_q == FN_SEARCH);
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;

endmodule

`default_nettype wire

### rtl/linear_probe_hash_table_unit.sv
// Top level: linear-probing hash table of nonzero keys.
`timescale 1ns / 1ps
`default_nettype none

// Open-addressed key table with linear probing from the home slot (key mod
// HOME_MODULUS, a zero residue meaning slot HOME_MODULUS) up to the last slot,
// without wraparound. After reset the block runs a clearing pass over all
// TABLE_SLOTS slots with busy_o high. An item is taken when start_i is high
// and busy_o is low. A zero key or unused operation code returns status
// invalid on done_o in the next cycle and leaves busy_o low. Any other item
// computes the residue in two steps (reciprocal multiply, then subtract),
// then checks the home slot, then probes slots from home on, each through a
// registered RAM read and a compare, until a hit or the last slot (up to
// TABLE_SLOTS - home slots probed, and none when the home slot is
// past the table). The result is shown on done_o, status_o and slot_o for
// exactly one cycle and must be taken then; a new item may be started in
// that same cycle.
module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
  parameter int HOME_MODULUS = HOME_MODULUS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [KEY_W-1:0]  key_i,
  output      logic              done_o,
  output      logic [STAT_W-1:0] status_o,
  output      logic [SLOT_W-1:0] slot_o
);

  cmd_t cmd;
  sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  lpht_dp #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .HOME_MODULUS (HOME_MODULUS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .func_i   (func_i),
    .key_i    (key_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .done_o   (done_o),
    .status_o (status_o),
    .slot_o   (slot_o)
  );

endmodule

`default_nettype wire

### sim/testbench.sv
// Testbench for linear_probe_hash_table_unit: a directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import lpht_pkg::*;

  localparam int NUM_SLOTS    = 32;
  localparam int HOME_MOD     = 10;
  localparam int RANDOM_OPS   = 1750;
  localparam int CALM_OPS     = 200;
  localparam int PHASE_OPS    = 250;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam bit TYPED        = 1'b1;
  localparam bit PREDICTED    = 1'b0;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                typed;
    reply_t            reply;
  } op_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [FUNC_W-1:0] func_i;
  logic [KEY_W-1:0]  key_i;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [SLOT_W-1:0] slot_o;

  reply_t           pending_replies[$];
  logic [KEY_W-1:0] shadow_keys [NUM_SLOTS];
  int unsigned      errors = 0;
  int unsigned      cycles = 0;
  bit               gaps_on;

  // Rows marked TYPED carry a reply read straight off the behavior.
  op_row_t directed_ops [22] = '{
    '{FN_SEARCH, 31'd5,          TYPED,     '{ST_NOT_FOUND, 5'd0}},
    '{FN_DELETE, 31'd5,          TYPED,     '{ST_NOT_FOUND, 5'd0}},
    '{FN_INSERT, 31'd0,          TYPED,     '{ST_INVALID,   5'd0}},
    '{FN_UNUSED, 31'd7,          TYPED,     '{ST_INVALID,   5'd0}},
    '{FN_INSERT, 31'h7FFF_FFFF,  TYPED,     '{ST_OK,        5'd7}},
    '{FN_INSERT, 31'd10,         TYPED,     '{ST_OK,        5'd10}},
    '{FN_INSERT, 31'd20,         PREDICTED, '{ST_OK,        5'd0}},
    '{FN_INSERT, 31'd1,          TYPED,     '{ST_OK,        5'd1}},
    '{FN_INSERT, 31'd1,          PREDICTED, '{ST_OK,        5'd0}},
    '{FN_SEARCH, 31'd1,          PREDICTED, '{ST_OK,        5'd0}},
    '{FN_DELETE, 31'd1,          PREDICTED, '{ST_OK,        5'd0}},
    '{FN_SEARCH, 31'd1,          PREDICTED, '{ST_OK,        5'd0}},
    '{FN_INSERT, 31'h7FFF_FFFF,  PREDICTED, '{ST_OK,        5'd0}},
    '{FN_SEARCH, 31'h7FFF_FFFF,  PREDICTED, '{ST_OK,        5'd0}},
    '{FN_SEARCH, 31'd2147483640, PREDICTED, '{ST_OK,        5'd0}},
    '{FN_DELETE, 31'd20,         PREDICTED, '{ST_OK,        5'd0}},
    '{FN_SEARCH, 31'd10,         PREDICTED, '{ST_OK,        5'd0}},
    '{FN_UNUSED, 31'd0,          TYPED,     '{ST_INVALID,   5'd0}},
    '{FN_DELETE, 31'd0,          TYPED,     '{ST_INVALID,   5'd0}},
    '{FN_SEARCH, 31'd0,          TYPED,     '{ST_INVALID,   5'd0}},
    '{FN_INSERT, 31'h4000_0000,  PREDICTED, '{ST_OK,        5'd0}},
    '{FN_INSERT, 31'd9,          PREDICTED, '{ST_OK,        5'd0}}
  };

  linear_probe_hash_table_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .func_i   (func_i),
    .key_i    (key_i),
    .done_o   (done_o),
    .status_o (status_o),
    .slot_o   (slot_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one operation to the shadow table and return the reply it gives.
  function automatic reply_t apply_op(input logic [FUNC_W-1:0] func,
                                      input logic [KEY_W-1:0] key);
    reply_t r;
    int     pos;
    r.status = ST_INVALID;
    r.slot   = '0;
    if (key == '0 || func == FN_UNUSED) return r;
    pos = int'(key % KEY_W'(HOME_MOD));
    if (pos == 0) pos = HOME_MOD;
    if (func == FN_INSERT) begin
      while (pos < NUM_SLOTS && shadow_keys[pos] != '0) pos++;
      if (pos < NUM_SLOTS) begin
        shadow_keys[pos] = key;
        r.status = ST_OK;
        r.slot   = SLOT_W'(pos);
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      while (pos < NUM_SLOTS && shadow_keys[pos] != key) pos++;
      if (pos < NUM_SLOTS) begin
        if (func == FN_DELETE) shadow_keys[pos] = '0;
        r.status = ST_OK;
        r.slot   = SLOT_W'(pos);
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    return r;
  endfunction

  // Favor keys already stored and small keys so probes collide and chains grow.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    k   = KEY_W'($urandom_range(1, 60));
    if (sel < 40) begin
      if (shadow_keys[$urandom_range(1, NUM_SLOTS - 1)] != '0)
        k = shadow_keys[$urandom_range(1, NUM_SLOTS - 1)];
    end else if (sel >= 90) begin
      k = 31'h7FFF_FFFF - KEY_W'($urandom_range(0, 20));
    end else if (sel >= 70) begin
      k = KEY_W'($urandom);
    end
    return k;
  endfunction

  task automatic issue(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                       input bit typed, input reply_t typed_reply);
    reply_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i  <= func;
    key_i   <= key;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted = apply_op(func, key);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  initial begin
    int unsigned       kind;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                filling;
    reply_t            unused_reply;
    unused_reply = '{ST_OK, 5'd0};
    rst_ni  = 1'b0;
    start_i = 1'b0;
    func_i  = FN_INSERT;
    key_i   = '0;
    gaps_on = 1'b1;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i])
      issue(directed_ops[i].func, directed_ops[i].key, directed_ops[i].typed,
            directed_ops[i].reply);

    // Alternate insert-heavy phases that fill the table with delete-heavy ones.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      gaps_on = (n < RANDOM_OPS - CALM_OPS);
      filling = ((n / PHASE_OPS) % 2) == 0;
      kind    = $urandom_range(0, 99);
      key     = pick_key();
      if (kind < 3) begin
        func = FUNC_W'($urandom_range(0, 3));
        key  = '0;
      end else if (kind < 6) begin
        func = FN_UNUSED;
      end else if (filling) begin
        func = (kind < 70) ? FN_INSERT : (kind < 82) ? FN_DELETE : FN_SEARCH;
      end else begin
        func = (kind < 60) ? FN_DELETE : (kind < 82) ? FN_SEARCH : FN_INSERT;
      end
      issue(func, key, PREDICTED, unused_reply);
    end
    start_i <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("linear_probe_hash_table_unit test passed");
    end else begin
      $display("linear_probe_hash_table_unit test failed");
    end
    $finish;
  end

  // Check each result transfer against the oldest outstanding reply.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                 $time, status_o, slot_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status_o);
        end
        if (slot_o !== want.slot) begin
          errors++;
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, want.slot, slot_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("linear_probe_hash_table_unit test failed");
      $finish;
    end
  end

endmodule
